[hdl/psfutp_pkg.sv]
`default_nettype none

package psfutp_pkg;

    localparam logic [7:0] MARK_NEXT_GLYPH = 8'hFF;
    localparam logic [7:0] MARK_SEQ_START  = 8'hFE;

    localparam int CODE_W  = 21;
    localparam int GLYPH_W = 16;

    localparam logic [15:0] GLYPH_LIMIT_RESET = 16'd256;
    localparam logic [15:0] CODE_MAX          = 16'hFFFE;

    // Register indexes on the configuration port.
    localparam logic REG_FORMAT_MODE = 1'b0;
    localparam logic REG_GLYPH_LIMIT = 1'b1;

    localparam logic MODE_V1 = 1'b0;
    localparam logic MODE_V2 = 1'b1;

    typedef struct packed {
        logic [7:0] table_byte;
        logic       start_of_table;
    } psf_in_t;

    typedef struct packed {
        logic [15:0] code_point;
        logic [15:0] glyph_index;
    } psf_out_t;

endpackage

`default_nettype wire

[hdl/psf_unicode_table_parser.sv]
// A request's map write, if any, is registered into the output register when the request is accepted.
// Throughput: one table byte per cycle unless m_ready stalls a held result; decode is a single
// pass between the decoder state and the output register, which refills while its result is taken.
// Reset (aresetn low, synchronous) clears the glyph counter, the decoder state and the
// output valid, and sets format_mode to 0 and glyph_limit to 256.
`default_nettype none

module psf_unicode_table_parser
    import psfutp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire psf_in_t     s_data,

    output logic             m_valid,
    input  wire logic        m_ready,
    output psf_out_t         m_data,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic                format_mode_reg;
    logic [15:0]         glyph_limit_reg;
    logic [GLYPH_W-1:0]  glyph_counter_reg, glyph_counter_next;
    logic [1:0]          bytes_remaining_reg, bytes_remaining_next;
    logic [CODE_W-1:0]   partial_code_reg, partial_code_next;
    logic                m_valid_reg, m_valid_next;
    psf_out_t            m_data_reg, m_data_next;

    logic                accept;
    logic                cfg_write;
    logic [GLYPH_W-1:0]  counter_eff;
    logic [1:0]          remaining_eff;
    logic [CODE_W-1:0]   partial_eff;
    logic [7:0]          b;
    logic                emit;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == REG_GLYPH_LIMIT) ? {16'd0, glyph_limit_reg}
                                                     : {31'd0, format_mode_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            format_mode_reg <= MODE_V1;
            glyph_limit_reg <= GLYPH_LIMIT_RESET;
        end else if (cfg_write) begin
            if (paddr[2] == REG_GLYPH_LIMIT) begin
                glyph_limit_reg <= pwdata[15:0];
            end else begin
                format_mode_reg <= pwdata[0];
            end
        end
    end

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign b       = s_data.table_byte;

    always_comb begin
        // A new table clears the decoder before this byte is looked at.
        counter_eff   = s_data.start_of_table ? '0 : glyph_counter_reg;
        remaining_eff = s_data.start_of_table ? '0 : bytes_remaining_reg;
        partial_eff   = s_data.start_of_table ? '0 : partial_code_reg;

        glyph_counter_next   = counter_eff;
        bytes_remaining_next = remaining_eff;
        partial_code_next    = partial_eff;
        emit                 = 1'b0;

        if (remaining_eff != 2'd0) begin
            // Any byte is taken as a continuation while a sequence is open.
            partial_code_next    = {partial_eff[CODE_W-7:0], b[5:0]};
            bytes_remaining_next = remaining_eff - 2'd1;
            emit                 = (remaining_eff == 2'd1);
        end else if (format_mode_reg == MODE_V1 && counter_eff >= glyph_limit_reg) begin
            emit = 1'b0;
        end else if (b == MARK_NEXT_GLYPH) begin
            glyph_counter_next = counter_eff + 16'd1;
        end else if (b == MARK_SEQ_START) begin
            emit = 1'b0;
        end else if (b[7] == 1'b0) begin
            partial_code_next = {13'd0, b};
            emit              = 1'b1;
        end else if (b[7:5] == 3'b110) begin
            partial_code_next    = {16'd0, b[4:0]};
            bytes_remaining_next = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
            partial_code_next    = {17'd0, b[3:0]};
            bytes_remaining_next = 2'd2;
        end else if (b[7:3] == 5'b11110 && format_mode_reg == MODE_V2) begin
            partial_code_next    = {18'd0, b[2:0]};
            bytes_remaining_next = 2'd3;
        end

        if (emit) begin
            emit = (partial_code_next != '0)
                && (partial_code_next[CODE_W-1:16] == '0)
                && (partial_code_next[15:0] <= CODE_MAX);
        end

        m_data_next.code_point  = partial_code_next[15:0];
        m_data_next.glyph_index = counter_eff;

        if (accept) begin
            m_valid_next = emit;
        end else begin
            m_valid_next = m_valid_reg && !m_ready;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            glyph_counter_reg   <= '0;
            bytes_remaining_reg <= '0;
            partial_code_reg    <= '0;
            m_valid_reg         <= 1'b0;
        end else begin
            if (accept) begin
                glyph_counter_reg   <= glyph_counter_next;
                bytes_remaining_reg <= bytes_remaining_next;
                partial_code_reg    <= partial_code_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_code_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg.code_point != 16'd0 && m_data_reg.code_point != 16'hFFFF))
        else $error("map write with out-of-range code point");

    a_reset_clears_valid: assert property (@(posedge aclk)
        !aresetn |=> !m_valid_reg)
        else $error("result valid after reset");

    a_state_holds_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && !accept) |=> ($stable(glyph_counter_reg) && $stable(bytes_remaining_reg)))
        else $error("decoder state changed without an accepted request");
`endif

endmodule

`default_nettype wire
